@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared request codes, status codes and controller states for the
// double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } deq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } deq_status_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_READ = 1'b1
    } deq_state_t;

    // Handshake between the controller and the result register.
    typedef struct packed {
        logic out_free;
    } deq_hs_in_t;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
    } deq_hs_out_t;

endpackage

@@ hdl/deq_req_if.sv @@
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: valid/ready with an operation code and an element value.
// ----------------------------------------------------------------------------
interface deq_req_if #(
    parameter int ELEMENT_BITS = 8
);
    import deq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [ELEMENT_BITS-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

@@ hdl/deq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: valid/ready with the queue view after one request.
// ----------------------------------------------------------------------------
interface deq_rsp_if #(
    parameter int ELEMENT_BITS = 8,
    parameter int COUNT_BITS   = 5
);
    import deq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ELEMENT_BITS-1:0] front_value;
    logic [ELEMENT_BITS-1:0] back_value;
    logic                    not_empty;
    logic [COUNT_BITS-1:0]   count;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, output front_value, output back_value,
                    output not_empty, output count, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input not_empty, input count, input status, output ready);
endinterface

@@ hdl/deq_ring_mem.sv @@
// ----------------------------------------------------------------------------
// deq_ring_mem
// Ring store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ring_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hdl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Head pointer, count and cached end elements; issues ring store accesses.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [deq_pkg::OP_W-1:0]         in_op,
    input  logic [ELEMENT_BITS-1:0]          in_value,
    input  deq_pkg::deq_hs_in_t              hs_in,
    output deq_pkg::deq_hs_out_t             hs_out,
    output logic [ELEMENT_BITS-1:0]          res_front,
    output logic [ELEMENT_BITS-1:0]          res_back,
    output logic [$clog2(DEPTH+1)-1:0]       res_count,
    output logic [deq_pkg::STATUS_W-1:0]     res_status,
    output logic                             mem_we,
    output logic [$clog2(DEPTH)-1:0]         mem_waddr,
    output logic [ELEMENT_BITS-1:0]          mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(DEPTH)-1:0]         mem_raddr,
    input  logic [ELEMENT_BITS-1:0]          mem_rdata
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_state_t              state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [ELEMENT_BITS-1:0] front_reg, front_next;
    logic [ELEMENT_BITS-1:0] back_reg, back_next;
    logic                    fill_front_reg, fill_front_next;

    logic                    accept;
    logic                    is_empty;
    logic                    is_full;
    logic [AW:0]             tail_sum;
    logic [AW-1:0]           tail_idx;
    logic [AW:0]             last2_sum;
    logic [AW-1:0]           last2_idx;
    logic [AW-1:0]           head_inc;
    logic [AW-1:0]           head_dec;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= CW'(DEPTH));

    // Slot past the back element, and the slot just before the back element.
    assign tail_sum  = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail_idx  = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : tail_sum[AW-1:0];
    assign last2_sum = tail_sum - (AW+1)'(2);
    assign last2_idx = (last2_sum >= (AW+1)'(DEPTH)) ? AW'(last2_sum - (AW+1)'(DEPTH))
                                                    : last2_sum[AW-1:0];
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CTRL_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            fill_front_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            fill_front_reg <= fill_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        fill_front_next  = fill_front_reg;
        hs_out.in_ready  = (state_reg == CTRL_IDLE) && hs_in.out_free;
        hs_out.res_valid = 1'b0;
        res_status       = ST_OK;
        mem_we           = 1'b0;
        mem_waddr        = tail_idx;
        mem_wdata        = in_value;
        mem_re           = 1'b0;
        mem_raddr        = head_inc;
        accept           = in_valid && hs_out.in_ready;

        case (state_reg)
            CTRL_IDLE:
            begin
                if (accept)
                begin
                    hs_out.res_valid = 1'b1;
                    case (deq_op_t'(in_op))
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status = ST_PUSH_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = tail_idx;
                                back_next  = in_value;
                                count_next = count_reg + CW'(1);
                                if (is_empty)
                                begin
                                    front_next = in_value;
                                end
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status = ST_PUSH_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                head_next  = head_dec;
                                front_next = in_value;
                                count_next = count_reg + CW'(1);
                                if (is_empty)
                                begin
                                    back_next = in_value;
                                end
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_POP_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                                // Fetch the new front unless the queue drains.
                                if (count_reg != CW'(1))
                                begin
                                    mem_re           = 1'b1;
                                    mem_raddr        = head_inc;
                                    fill_front_next  = 1'b1;
                                    state_next       = CTRL_READ;
                                    hs_out.res_valid = 1'b0;
                                end
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_POP_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    mem_re           = 1'b1;
                                    mem_raddr        = last2_idx;
                                    fill_front_next  = 1'b0;
                                    state_next       = CTRL_READ;
                                    hs_out.res_valid = 1'b0;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CTRL_READ:
            begin
                // Load the refetched end element and report.
                hs_out.res_valid = 1'b1;
                state_next       = CTRL_IDLE;
                if (fill_front_reg)
                begin
                    front_next = mem_rdata;
                end
                else
                begin
                    back_next = mem_rdata;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase

        res_count = count_next;
        res_front = (count_next != '0) ? front_next : '0;
        res_back  = (count_next != '0) ? back_next : '0;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count exceeds capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer outside ring");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CTRL_READ |=> state_reg == CTRL_IDLE)
        else $error("refetch state held longer than one cycle");

    a_read_reports: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CTRL_READ |-> hs_out.res_valid && !hs_out.in_ready)
        else $error("refetch cycle must report and block new transfers");
endmodule

@@ hdl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue in a ring store with head pointer and count.
// ----------------------------------------------------------------------------
// Each request transfer produces exactly one result transfer showing the
// queue after the request: front and back element (zero when empty), a
// non-empty flag, the count and a status (ok, pop from empty, push into full).
// Pushes, clears, refused requests and pops that leave the queue empty are
// answered from the idle state and can stream at one per cycle unless a held
// result stalls them. A pop that leaves elements behind passes through a read
// state that blocks new requests: the new front or back element must be read
// from the ring store's single read port. End elements are registered, so the
// store is read only on those pops. A result register sits on the output; a
// new request is taken when that register is empty or when the consumer takes
// the waiting result in the same cycle, so a result that the consumer holds
// back stalls the request side. No clearing pass is needed after reset: only
// slots holding elements are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_hs_in_t              hs_in;
    deq_hs_out_t             hs_out;
    logic [ELEMENT_BITS-1:0] res_front;
    logic [ELEMENT_BITS-1:0] res_back;
    logic [CW-1:0]           res_count;
    logic [STATUS_W-1:0]     res_status;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [ELEMENT_BITS-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [ELEMENT_BITS-1:0] mem_rdata;

    // Result register
    logic                    rsp_valid_reg;
    logic [ELEMENT_BITS-1:0] rsp_front_reg;
    logic [ELEMENT_BITS-1:0] rsp_back_reg;
    logic [CW-1:0]           rsp_count_reg;
    logic [STATUS_W-1:0]     rsp_status_reg;

    // The result register is free when empty or draining this cycle.
    assign hs_in.out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready      = hs_out.in_ready;

    deq_ctrl #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_op      (req.op),
        .in_value   (req.value),
        .hs_in      (hs_in),
        .hs_out     (hs_out),
        .res_front  (res_front),
        .res_back   (res_back),
        .res_count  (res_count),
        .res_status (res_status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    deq_ring_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ELEMENT_BITS)
    ) u_ring_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold the result until the consumer takes it; load a new one when ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (hs_out.res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hs_out.res_valid)
        begin
            rsp_front_reg  <= res_front;
            rsp_back_reg   <= res_back;
            rsp_count_reg  <= res_count;
            rsp_status_reg <= res_status;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.front_value = rsp_front_reg;
    assign rsp.back_value  = rsp_back_reg;
    assign rsp.count       = rsp_count_reg;
    assign rsp.not_empty   = (rsp_count_reg != '0);
    assign rsp.status      = rsp_status_reg;
endmodule
